### design/signed_five_digit_display_encoder_macros.svh
// Assertion macros used by the checker file of the display encoder.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef SIGNED_FIVE_DIGIT_DISPLAY_ENCODER_MACROS_SVH
`define SIGNED_FIVE_DIGIT_DISPLAY_ENCODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFDDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold once the delay dly has passed after the antecedent.
`define SFDDE_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

### design/sfdde_pkg.sv
`default_nettype none

package sfdde_pkg;

  localparam int unsigned VALUE_BITS_DEF = 18;
  localparam int unsigned MAG_W          = 17;
  localparam int unsigned DIGITS         = 5;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned OCT_W          = 3;
  localparam int unsigned CODE_W         = 5;
  localparam int unsigned FMT_W          = 6;
  localparam int unsigned LATENCY        = 4;

  localparam logic [MAG_W-1:0]  DEC_MAX    = 17'd99999;
  localparam logic [MAG_W-1:0]  OCT_MAX    = 17'd32767;
  localparam logic [CODE_W-1:0] BLANK_CODE = 5'd0;

  // Reciprocal constants: floor(x / 10^k) == (x * R) >> S for every x below 2^17.
  localparam int unsigned RECIP_W = 18;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;

  localparam logic [RECIP_W-1:0] R10    = 18'd52429;
  localparam int unsigned        S10    = 19;
  localparam int unsigned        Q10_W  = 14;
  localparam logic [RECIP_W-1:0] R100   = 18'd167773;
  localparam int unsigned        S100   = 24;
  localparam int unsigned        Q100_W = 10;
  localparam logic [RECIP_W-1:0] R1K    = 18'd67109;
  localparam int unsigned        S1K    = 26;
  localparam int unsigned        Q1K_W  = 7;
  localparam logic [RECIP_W-1:0] R10K   = 18'd107375;
  localparam int unsigned        S10K   = 30;
  localparam int unsigned        Q10K_W = 4;

  // Sign and blanking decisions travel with the magnitude down the pipeline.
  // blank[0] belongs to the most significant digit.
  typedef struct packed {
    logic              plus;
    logic              minus;
    logic              dec;
    logic [DIGITS-1:0] blank;
  } info_t;

  // Low four bits of 10 * q; they depend only on the low bits of q.
  function automatic logic [DIGIT_W-1:0] mul10_lo(input logic [DIGIT_W-1:0] q);
    mul10_lo = {q[2:0], 1'b0} + {q[0], 3'b000};
  endfunction

  function automatic logic [CODE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
    logic [CODE_W-1:0] code;
    unique case (digit)
      4'd0:    code = 5'd21;
      4'd1:    code = 5'd3;
      4'd2:    code = 5'd25;
      4'd3:    code = 5'd27;
      4'd4:    code = 5'd15;
      4'd5:    code = 5'd30;
      4'd6:    code = 5'd28;
      4'd7:    code = 5'd19;
      4'd8:    code = 5'd29;
      default: code = 5'd31;
    endcase
    seg_code = code;
  endfunction

endpackage

`default_nettype wire

### design/signed_five_digit_display_encoder.sv
// Channel   Direction  Handshake         Payload
// request   in         start_i, busy_o   value_i, blank_all_i, decimal_mode_i, format_mask_i
// result    out        done_o            plus_lamp_o, minus_lamp_o, digit_*_code_o
//
// A request is taken at every clock edge where start_i is high; busy_o stays low.
// A request passes through four registers: input register, magnitude register,
// quotient register and result register. done_o rises when the result register
// is loaded and marks the cycle in which the result is valid.
// One request per cycle is sustained; the reciprocal multiplies set the clock.
// Reset clears only the valid bits of the pipeline; the receiver cannot stall.
`default_nettype none

module signed_five_digit_display_encoder #(
  parameter int unsigned VALUE_BITS = sfdde_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [VALUE_BITS-1:0]  value_i,
  input  logic                          blank_all_i,
  input  logic                          decimal_mode_i,
  input  logic [sfdde_pkg::FMT_W-1:0]   format_mask_i,
  output logic                          done_o,
  output logic                          plus_lamp_o,
  output logic                          minus_lamp_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_one_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_two_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_three_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_four_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_five_code_o
);

  logic                         mag_valid;
  logic [sfdde_pkg::MAG_W-1:0]  mag;
  sfdde_pkg::info_t             info;

  assign busy_o = 1'b0;

  sfdde_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .value_i        (value_i),
    .blank_all_i    (blank_all_i),
    .decimal_mode_i (decimal_mode_i),
    .format_mask_i  (format_mask_i),
    .valid_o        (mag_valid),
    .mag_o          (mag),
    .info_o         (info)
  );

  sfdde_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (mag_valid),
    .mag_i              (mag),
    .info_i             (info),
    .done_o             (done_o),
    .plus_lamp_o        (plus_lamp_o),
    .minus_lamp_o       (minus_lamp_o),
    .digit_one_code_o   (digit_one_code_o),
    .digit_two_code_o   (digit_two_code_o),
    .digit_three_code_o (digit_three_code_o),
    .digit_four_code_o  (digit_four_code_o),
    .digit_five_code_o  (digit_five_code_o)
  );

endmodule

`default_nettype wire

### design/sfdde_front.sv
`default_nettype none

module sfdde_front #(
  parameter int unsigned VALUE_BITS = sfdde_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [VALUE_BITS-1:0]          value_i,
  input  logic                                  blank_all_i,
  input  logic                                  decimal_mode_i,
  input  logic [sfdde_pkg::FMT_W-1:0]           format_mask_i,
  output logic                                  valid_o,
  output logic [sfdde_pkg::MAG_W-1:0]           mag_o,
  output sfdde_pkg::info_t                      info_o
);

  localparam logic [VALUE_BITS-1:0] DecMaxExt = VALUE_BITS'(sfdde_pkg::DEC_MAX);
  localparam logic [VALUE_BITS-1:0] OctMaxExt = VALUE_BITS'(sfdde_pkg::OCT_MAX);
  localparam logic [VALUE_BITS-1:0] OneExt    = VALUE_BITS'(1);

  logic                          in_valid_q;
  logic [VALUE_BITS-1:0]         value_q;
  logic                          blank_q;
  logic                          dec_q;
  logic [sfdde_pkg::FMT_W-1:0]   fmt_q;

  logic                          neg;
  logic [VALUE_BITS-1:0]         abs_val;
  logic [sfdde_pkg::MAG_W-1:0]   mag_d, mag_q;
  sfdde_pkg::info_t              info_d, info_q;
  logic                          valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      in_valid_q <= start_i;
      valid_q    <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_i;
    blank_q <= blank_all_i;
    dec_q   <= decimal_mode_i;
    fmt_q   <= format_mask_i;
    mag_q   <= mag_d;
    info_q  <= info_d;
  end

  assign neg     = value_q[VALUE_BITS-1];
  assign abs_val = neg ? (~value_q + OneExt) : value_q;

  always_comb begin
    if (dec_q) begin
      mag_d = (abs_val > DecMaxExt) ? sfdde_pkg::DEC_MAX : abs_val[sfdde_pkg::MAG_W-1:0];
    end else if (neg) begin
      // Negative values have no octal form; they show as zero.
      mag_d = '0;
    end else begin
      mag_d = (value_q > OctMaxExt) ? sfdde_pkg::OCT_MAX : value_q[sfdde_pkg::MAG_W-1:0];
    end
  end

  always_comb begin
    info_d.plus  = !blank_q && dec_q && !fmt_q[0] && !neg;
    info_d.minus = !blank_q && dec_q && !fmt_q[0] && neg;
    info_d.dec   = dec_q;
    info_d.blank = fmt_q[sfdde_pkg::FMT_W-1:1] | {sfdde_pkg::DIGITS{blank_q}};
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign info_o  = info_q;

endmodule

`default_nettype wire

### design/sfdde_back.sv
`default_nettype none

module sfdde_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [sfdde_pkg::MAG_W-1:0]   mag_i,
  input  sfdde_pkg::info_t              info_i,
  output logic                          done_o,
  output logic                          plus_lamp_o,
  output logic                          minus_lamp_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_one_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_two_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_three_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_four_code_o,
  output logic [sfdde_pkg::CODE_W-1:0]  digit_five_code_o
);

  localparam int unsigned PW = sfdde_pkg::PROD_W;
  localparam int unsigned DW = sfdde_pkg::DIGIT_W;
  localparam int unsigned OW = sfdde_pkg::OCT_W;
  localparam int unsigned ND = sfdde_pkg::DIGITS;

  logic [PW-1:0] mag_ext;
  logic [PW-1:0] p10, p100, p1k, p10k;

  logic [sfdde_pkg::Q10_W-1:0]  q10_q;
  logic [sfdde_pkg::Q100_W-1:0] q100_q;
  logic [sfdde_pkg::Q1K_W-1:0]  q1k_q;
  logic [sfdde_pkg::Q10K_W-1:0] q10k_q;
  logic [sfdde_pkg::MAG_W-1:0]  mag_q;
  sfdde_pkg::info_t             info_q;
  logic                         valid_q;

  logic [DW-1:0]                     dec_dig [ND];
  logic [DW-1:0]                     digit   [ND];
  logic [sfdde_pkg::CODE_W-1:0]      code_d  [ND];
  logic [sfdde_pkg::CODE_W-1:0]      code_q  [ND];
  logic                              plus_q;
  logic                              minus_q;
  logic                              done_q;

  // All four quotients come from parallel reciprocal multiplies.
  assign mag_ext = {{sfdde_pkg::RECIP_W{1'b0}}, mag_i};
  assign p10  = mag_ext * {{sfdde_pkg::MAG_W{1'b0}}, sfdde_pkg::R10};
  assign p100 = mag_ext * {{sfdde_pkg::MAG_W{1'b0}}, sfdde_pkg::R100};
  assign p1k  = mag_ext * {{sfdde_pkg::MAG_W{1'b0}}, sfdde_pkg::R1K};
  assign p10k = mag_ext * {{sfdde_pkg::MAG_W{1'b0}}, sfdde_pkg::R10K};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q10_q  <= p10[sfdde_pkg::S10 +: sfdde_pkg::Q10_W];
    q100_q <= p100[sfdde_pkg::S100 +: sfdde_pkg::Q100_W];
    q1k_q  <= p1k[sfdde_pkg::S1K +: sfdde_pkg::Q1K_W];
    q10k_q <= p10k[sfdde_pkg::S10K +: sfdde_pkg::Q10K_W];
    mag_q  <= mag_i;
    info_q <= info_i;
  end

  // Each decimal digit is floor(x / 10^k) - 10 * floor(x / 10^(k+1)); the
  // difference is below ten, so four bits of arithmetic are enough.
  always_comb begin
    dec_dig[0] = q10k_q;
    dec_dig[1] = q1k_q[DW-1:0]  - sfdde_pkg::mul10_lo(q10k_q);
    dec_dig[2] = q100_q[DW-1:0] - sfdde_pkg::mul10_lo(q1k_q[DW-1:0]);
    dec_dig[3] = q10_q[DW-1:0]  - sfdde_pkg::mul10_lo(q100_q[DW-1:0]);
    dec_dig[4] = mag_q[DW-1:0]  - sfdde_pkg::mul10_lo(q10_q[DW-1:0]);
  end

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      digit[i]  = info_q.dec ? dec_dig[i] : {1'b0, mag_q[OW*(ND-1-i) +: OW]};
      code_d[i] = info_q.blank[i] ? sfdde_pkg::BLANK_CODE : sfdde_pkg::seg_code(digit[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    plus_q  <= info_q.plus;
    minus_q <= info_q.minus;
    for (int i = 0; i < ND; i++) begin
      code_q[i] <= code_d[i];
    end
  end

  assign done_o             = done_q;
  assign plus_lamp_o        = plus_q;
  assign minus_lamp_o       = minus_q;
  assign digit_one_code_o   = code_q[0];
  assign digit_two_code_o   = code_q[1];
  assign digit_three_code_o = code_q[2];
  assign digit_four_code_o  = code_q[3];
  assign digit_five_code_o  = code_q[4];

endmodule

`default_nettype wire

### design/sfdde_checker.sv
`default_nettype none
`include "signed_five_digit_display_encoder_macros.svh"

module sfdde_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  logic                          blank_all_i,
  input  logic                          decimal_mode_i,
  input  logic [sfdde_pkg::FMT_W-1:0]   format_mask_i,
  input  logic                          done_o,
  input  logic                          plus_lamp_o,
  input  logic                          minus_lamp_o,
  input  logic [sfdde_pkg::CODE_W-1:0]  digit_one_code_o,
  input  logic [sfdde_pkg::CODE_W-1:0]  digit_two_code_o,
  input  logic [sfdde_pkg::CODE_W-1:0]  digit_three_code_o,
  input  logic [sfdde_pkg::CODE_W-1:0]  digit_four_code_o,
  input  logic [sfdde_pkg::CODE_W-1:0]  digit_five_code_o
);

  logic accepted;
  logic all_blank;
  logic lamp_on;
  logic sign_ok;

  assign accepted  = start_i && !busy_o;
  assign all_blank = (digit_one_code_o == sfdde_pkg::BLANK_CODE) &&
                     (digit_two_code_o == sfdde_pkg::BLANK_CODE) &&
                     (digit_three_code_o == sfdde_pkg::BLANK_CODE) &&
                     (digit_four_code_o == sfdde_pkg::BLANK_CODE) &&
                     (digit_five_code_o == sfdde_pkg::BLANK_CODE) &&
                     !plus_lamp_o && !minus_lamp_o;
  assign lamp_on   = plus_lamp_o || minus_lamp_o;
  assign sign_ok   = decimal_mode_i && !blank_all_i && !format_mask_i[0];

  // Every request yields exactly one result a fixed time later.
  `SFDDE_ASSERT_DELAY(a_result_follows, accepted, sfdde_pkg::LATENCY, done_o, "request lost")
  `SFDDE_ASSERT_DELAY(a_no_spurious, !accepted, sfdde_pkg::LATENCY, !done_o, "spurious result")
  `SFDDE_ASSERT_IMPL(a_one_lamp, done_o, !(plus_lamp_o && minus_lamp_o), "both sign lamps lit")
  `SFDDE_ASSERT_IMPL(a_lamp_mode, done_o && lamp_on, $past(sign_ok, sfdde_pkg::LATENCY), "bad lamp")
  `SFDDE_ASSERT_IMPL(a_blank_all, done_o && $past(blank_all_i, sfdde_pkg::LATENCY), all_blank, "blank request not blank")

endmodule

bind signed_five_digit_display_encoder sfdde_checker u_checker (.*);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned VB = sfdde_pkg::VALUE_BITS_DEF;

  // Segment patterns for the digits 0 to 9.
  localparam logic [sfdde_pkg::CODE_W-1:0] DIGIT_SEGS [10] = '{
    5'd21, 5'd3, 5'd25, 5'd27, 5'd15, 5'd30, 5'd28, 5'd19, 5'd29, 5'd31
  };
  localparam int DEC_BASE = 10;
  localparam int OCT_BASE = 8;
  localparam int DEC_TOP_WEIGHT = 10000;
  localparam int OCT_TOP_WEIGHT = 4096;
  localparam int MASK_SIGN = 0;

  typedef struct packed {
    logic signed [VB-1:0]          value;
    logic                          blank;
    logic                          dec;
    logic [sfdde_pkg::FMT_W-1:0]   mask;
  } disp_req_t;

  // code[0] is the most significant digit.
  typedef struct packed {
    logic                                                plus;
    logic                                                minus;
    logic [sfdde_pkg::DIGITS-1:0][sfdde_pkg::CODE_W-1:0] code;
  } disp_res_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic signed [VB-1:0]           value_i = '0;
  logic                           blank_all_i = 1'b0;
  logic                           decimal_mode_i = 1'b0;
  logic [sfdde_pkg::FMT_W-1:0]    format_mask_i = '0;
  logic                           busy_o;
  logic                           done_o;
  logic                           plus_lamp_o;
  logic                           minus_lamp_o;
  logic [sfdde_pkg::CODE_W-1:0]   digit_one_code_o;
  logic [sfdde_pkg::CODE_W-1:0]   digit_two_code_o;
  logic [sfdde_pkg::CODE_W-1:0]   digit_three_code_o;
  logic [sfdde_pkg::CODE_W-1:0]   digit_four_code_o;
  logic [sfdde_pkg::CODE_W-1:0]   digit_five_code_o;

  disp_req_t pending_reqs[$];
  disp_res_t expected_displays[$];
  disp_req_t driven_req;
  disp_res_t shown;
  int        burst_left = 1;
  int        gap_left = 0;
  int        fail_count = 0;

  signed_five_digit_display_encoder #(
    .VALUE_BITS(VB)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .value_i           (value_i),
    .blank_all_i       (blank_all_i),
    .decimal_mode_i    (decimal_mode_i),
    .format_mask_i     (format_mask_i),
    .done_o            (done_o),
    .plus_lamp_o       (plus_lamp_o),
    .minus_lamp_o      (minus_lamp_o),
    .digit_one_code_o  (digit_one_code_o),
    .digit_two_code_o  (digit_two_code_o),
    .digit_three_code_o(digit_three_code_o),
    .digit_four_code_o (digit_four_code_o),
    .digit_five_code_o (digit_five_code_o)
  );

  assign shown = {plus_lamp_o, minus_lamp_o, digit_five_code_o, digit_four_code_o,
                  digit_three_code_o, digit_two_code_o, digit_one_code_o};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic disp_res_t encode_display(input disp_req_t r);
    disp_res_t res;
    int        num;
    int        mag;
    int        wt;
    int        d;
    res = '0;
    num = int'(r.value);
    if (r.blank) return res;
    if (r.dec) begin
      mag = (num < 0) ? -num : num;
      if (mag > int'(sfdde_pkg::DEC_MAX)) mag = int'(sfdde_pkg::DEC_MAX);
      wt = DEC_TOP_WEIGHT;
      if (!r.mask[MASK_SIGN]) begin
        res.plus  = (num >= 0);
        res.minus = (num < 0);
      end
    end else begin
      // Negative values have no octal form here and are shown as zero.
      mag = (num < 0) ? 0 : num;
      if (mag > int'(sfdde_pkg::OCT_MAX)) mag = int'(sfdde_pkg::OCT_MAX);
      wt = OCT_TOP_WEIGHT;
    end
    for (int i = 0; i < sfdde_pkg::DIGITS; i++) begin
      d = mag / wt;
      mag = mag - d * wt;
      if (d > 9) d = 9;
      res.code[i] = r.mask[i + 1] ? sfdde_pkg::BLANK_CODE : DIGIT_SEGS[d];
      wt = wt / (r.dec ? DEC_BASE : OCT_BASE);
    end
    return res;
  endfunction

  task automatic add_req(input int v, input bit blank, input bit dec, input int mask);
    disp_req_t r;
    r.value = v[VB-1:0];
    r.blank = blank;
    r.dec   = dec;
    r.mask  = mask[sfdde_pkg::FMT_W-1:0];
    pending_reqs.push_back(r);
  endtask

  // Driver: issues requests in bursts separated by random gaps.
  always @(posedge clk_i) begin : driver
    logic go;
    logic taken;
    go = start_i;
    taken = start_i && !busy_o;
    if (rst_ni) begin
      if (taken) expected_displays.push_back(encode_display(driven_req));
      if (!start_i || taken) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0) begin
          driven_req = pending_reqs.pop_front();
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20)
                                                   : $urandom_range(1, 4);
          end
        end
        start_i <= go;
        if (go) begin
          value_i        <= driven_req.value;
          blank_all_i    <= driven_req.blank;
          decimal_mode_i <= driven_req.dec;
          format_mask_i  <= driven_req.mask;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest request.
  always @(posedge clk_i) begin : monitor
    disp_res_t want;
    if (rst_ni && done_o) begin
      if (expected_displays.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual %h",
                 $time, shown);
        fail_count++;
      end else begin
        want = expected_displays.pop_front();
        if (shown.plus !== want.plus) begin
          $display("%0t: plus lamp expected %0d, actual %0d", $time, want.plus, shown.plus);
          fail_count++;
        end
        if (shown.minus !== want.minus) begin
          $display("%0t: minus lamp expected %0d, actual %0d",
                   $time, want.minus, shown.minus);
          fail_count++;
        end
        for (int i = 0; i < sfdde_pkg::DIGITS; i++) begin
          if (shown.code[i] !== want.code[i]) begin
            $display("%0t: digit %0d code expected %0d, actual %0d",
                     $time, i + 1, want.code[i], shown.code[i]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int v;
    int kind;
    // Zero, unit steps, saturation edges and the signed extremes in both modes.
    add_req(0, 0, 1, 0);
    add_req(0, 0, 0, 0);
    add_req(1, 0, 1, 0);
    add_req(-1, 0, 1, 0);
    add_req(-8, 0, 1, 0);
    add_req(99999, 0, 1, 0);
    add_req(100000, 0, 1, 0);
    add_req(-99999, 0, 1, 0);
    add_req(-131072, 0, 1, 0);
    add_req(131071, 0, 1, 0);
    add_req(32767, 0, 0, 0);
    add_req(32768, 0, 0, 0);
    add_req(131071, 0, 0, 0);
    add_req(-1, 0, 0, 0);
    add_req(-131072, 0, 0, 0);
    // Blanking of single positions, of all of them, and by the blank flag.
    add_req(12345, 0, 1, 6'b000001);
    add_req(-54321, 0, 1, 6'b111111);
    add_req(98765, 0, 1, 6'b000010);
    add_req(-43210, 0, 1, 6'b000100);
    add_req(24680, 0, 0, 6'b001000);
    add_req(13579, 0, 1, 6'b010000);
    add_req(4095, 0, 0, 6'b100000);
    add_req(-777, 1, 1, 0);
    add_req(12345, 1, 0, 6'b010101);
    for (int n = 0; n < 400; n++) begin
      kind = $urandom_range(0, 5);
      case (kind)
        0: v = int'($urandom);
        1: v = $urandom_range(0, 400) - 200;
        2: v = ($urandom_range(0, 1) ? 1 : -1) *
               (int'(sfdde_pkg::DEC_MAX) - 50 + $urandom_range(0, 100));
        3: v = int'(sfdde_pkg::OCT_MAX) - 50 + $urandom_range(0, 100);
        4: v = ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, 99999);
        default: v = $urandom_range(0, 32767);
      endcase
      add_req(v, $urandom_range(0, 9) == 0, $urandom_range(0, 1),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 0);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || start_i) @(posedge clk_i);
    while (expected_displays.size() != 0) @(posedge clk_i);
    repeat (4 * sfdde_pkg::LATENCY) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
